// File: rtl/sapg_pkg.sv
package sapg_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int MAX_CH       = 8;
  localparam int ANGLE_FIELDS = 6;
  localparam int PIN_FIELDS   = 6;

  localparam int ANGLE_W  = 8;
  localparam int WIDTH_W  = 12;
  localparam int COUNT_W  = 16;
  localparam int SPAN_W   = 12;

  // angle * span, then floor(/180) as multiply by ceil(2^28/180) and shift
  localparam int PROD_W      = ANGLE_W + SPAN_W;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1491309);
  localparam int MUL_W       = PROD_W + RECIP_W;
  localparam int QUOT_W      = 13;
  localparam int SUM_W       = QUOT_W + 1;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_PERIOD    = 3'd0;
  localparam logic [2:0] REG_ARM_MIN   = 3'd1;
  localparam logic [2:0] REG_ARM_SPAN  = 3'd2;
  localparam logic [2:0] REG_GRIP_MIN  = 3'd3;
  localparam logic [2:0] REG_GRIP_SPAN = 3'd4;
  localparam logic [2:0] REG_CLAMP     = 3'd5;

  localparam logic [COUNT_W-1:0] PERIOD_RST    = 16'd40000;
  localparam logic [WIDTH_W-1:0] ARM_MIN_RST   = 12'd500;
  localparam logic [WIDTH_W-1:0] ARM_SPAN_RST  = 12'd1950;
  localparam logic [WIDTH_W-1:0] GRIP_MIN_RST  = 12'd600;
  localparam logic [WIDTH_W-1:0] GRIP_SPAN_RST = 12'd600;
  localparam logic [WIDTH_W-1:0] CLAMP_RST     = 12'd2500;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ANGLE_W-1:0] angle_0;
    logic [ANGLE_W-1:0] angle_1;
    logic [ANGLE_W-1:0] angle_2;
    logic [ANGLE_W-1:0] angle_3;
    logic [ANGLE_W-1:0] angle_4;
    logic [ANGLE_W-1:0] angle_5;
  } item_t;

  typedef struct packed {
    logic pin_0;
    logic pin_1;
    logic pin_2;
    logic pin_3;
    logic pin_4;
    logic pin_5;
    logic period_start;
  } result_t;

endpackage

// File: rtl/servo_angle_pwm_generator.sv
// channel  | direction | handshake                   | payload
// item     | in        | item_valid / item_stall     | sapg_pkg::item_t
// result   | out       | result_valid / result_stall | sapg_pkg::result_t
// config   | in        | APB write/read              | 32-bit register data
//
// One beat in per cycle while item_stall is low; each accepted beat passes the input register,
// product stage, reciprocal-multiply stage and result register before result_valid rises.
// Counter and widths update as the beat enters the result register, in order.
// A stalled result freezes the pipe; item_stall rises only once all four stages hold a beat.
// rst clears counter and widths and loads the register defaults.
module servo_angle_pwm_generator #(
  parameter int CHANNELS = sapg_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  sapg_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output sapg_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sapg_pkg::ADDR_W-1:0]  paddr,
  input  logic [sapg_pkg::DATA_W-1:0]  pwdata,
  output logic [sapg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW = sapg_pkg::ANGLE_W;
  localparam int WW = sapg_pkg::WIDTH_W;
  localparam int CW = sapg_pkg::COUNT_W;
  localparam int PW = sapg_pkg::PROD_W;
  localparam int QW = sapg_pkg::QUOT_W;
  localparam int SW = sapg_pkg::SUM_W;
  localparam int MW = sapg_pkg::MUL_W;

  // configuration
  logic [CW-1:0] period_ticks;
  logic [WW-1:0] arm_min_us, arm_span_us, grip_min_us, grip_span_us, clamp_us;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= sapg_pkg::PERIOD_RST;
      arm_min_us   <= sapg_pkg::ARM_MIN_RST;
      arm_span_us  <= sapg_pkg::ARM_SPAN_RST;
      grip_min_us  <= sapg_pkg::GRIP_MIN_RST;
      grip_span_us <= sapg_pkg::GRIP_SPAN_RST;
      clamp_us     <= sapg_pkg::CLAMP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sapg_pkg::REG_PERIOD:    period_ticks <= pwdata[CW-1:0];
        sapg_pkg::REG_ARM_MIN:   arm_min_us   <= pwdata[WW-1:0];
        sapg_pkg::REG_ARM_SPAN:  arm_span_us  <= pwdata[WW-1:0];
        sapg_pkg::REG_GRIP_MIN:  grip_min_us  <= pwdata[WW-1:0];
        sapg_pkg::REG_GRIP_SPAN: grip_span_us <= pwdata[WW-1:0];
        sapg_pkg::REG_CLAMP:     clamp_us     <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sapg_pkg::REG_PERIOD:    prdata = sapg_pkg::DATA_W'(period_ticks);
      sapg_pkg::REG_ARM_MIN:   prdata = sapg_pkg::DATA_W'(arm_min_us);
      sapg_pkg::REG_ARM_SPAN:  prdata = sapg_pkg::DATA_W'(arm_span_us);
      sapg_pkg::REG_GRIP_MIN:  prdata = sapg_pkg::DATA_W'(grip_min_us);
      sapg_pkg::REG_GRIP_SPAN: prdata = sapg_pkg::DATA_W'(grip_span_us);
      sapg_pkg::REG_CLAMP:     prdata = sapg_pkg::DATA_W'(clamp_us);
      default:                 prdata = '0;
    endcase
  end

  // pipe control
  logic v1, v2, v3;
  logic en1, en2, en3, en_out;

  assign en_out     = !result_valid || !result_stall;
  assign en3        = en_out || !v3;
  assign en2        = en3 || !v2;
  assign en1        = en2 || !v1;
  assign item_stall = !en1;

  // stage 1: input register
  logic          k1;
  logic [AW-1:0] ang1 [CHANNELS];
  logic [AW-1:0] ang_all [sapg_pkg::MAX_CH];

  always_comb begin
    for (int i = 0; i < sapg_pkg::MAX_CH; i++) ang_all[i] = '0;
    ang_all[0] = item.angle_0;
    ang_all[1] = item.angle_1;
    ang_all[2] = item.angle_2;
    ang_all[3] = item.angle_3;
    ang_all[4] = item.angle_4;
    ang_all[5] = item.angle_5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item_valid;
    end
    if (en1) begin
      k1 <= item.kind;
      for (int i = 0; i < CHANNELS; i++) ang1[i] <= ang_all[i];
    end
  end

  // stage 2: angle * span
  logic          k2;
  logic [PW-1:0] prod2 [CHANNELS];
  logic [PW-1:0] prod_c [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (i == CHANNELS - 1) begin
        prod_c[i] = PW'(ang1[i]) * PW'(grip_span_us);
      end else begin
        prod_c[i] = PW'(ang1[i]) * PW'(arm_span_us);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      k2 <= k1;
      for (int i = 0; i < CHANNELS; i++) prod2[i] <= prod_c[i];
    end
  end

  // stage 3: floor(prod / 180)
  logic          k3;
  logic [QW-1:0] quot3 [CHANNELS];
  logic [MW-1:0] mul_c [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      mul_c[i] = MW'(prod2[i]) * MW'(sapg_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      k3 <= k2;
      for (int i = 0; i < CHANNELS; i++) begin
        quot3[i] <= mul_c[i][sapg_pkg::RECIP_SHIFT +: QW];
      end
    end
  end

  // stage 4: widths, period counter, pins
  logic [CW-1:0] tick_count, tick_count_next;
  logic [WW-1:0] active_width [CHANNELS];
  logic [WW-1:0] active_width_next [CHANNELS];
  logic [WW-1:0] pending_width [CHANNELS];
  logic [WW-1:0] width_c [CHANNELS];
  logic [SW-1:0] sum_c [CHANNELS];
  logic [CW:0]   cnt_inc;
  logic          wrap;
  logic          do_step;
  logic [sapg_pkg::PIN_FIELDS-1:0] pins;
  sapg_pkg::result_t result_next;

  assign do_step = en_out && v3;
  assign cnt_inc = {1'b0, tick_count} + 1'b1;
  assign wrap    = (k3 == sapg_pkg::KIND_TICK) && (cnt_inc >= {1'b0, period_ticks});

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (i == CHANNELS - 1) begin
        sum_c[i]   = SW'(grip_min_us) + SW'(quot3[i]);
        width_c[i] = (sum_c[i] > SW'(sapg_pkg::WIDTH_MAX)) ? sapg_pkg::WIDTH_MAX
                                                           : sum_c[i][WW-1:0];
      end else begin
        sum_c[i]   = SW'(arm_min_us) + SW'(quot3[i]);
        width_c[i] = (sum_c[i] > SW'(clamp_us)) ? clamp_us : sum_c[i][WW-1:0];
      end
    end
  end

  always_comb begin
    if (k3 == sapg_pkg::KIND_TICK) begin
      tick_count_next = wrap ? '0 : cnt_inc[CW-1:0];
    end else begin
      tick_count_next = tick_count;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      active_width_next[i] = wrap ? pending_width[i] : active_width[i];
    end
    pins = '0;
    for (int j = 0; j < sapg_pkg::PIN_FIELDS; j++) begin
      if (j < CHANNELS) begin
        pins[j] = ({1'b0, tick_count_next} < {(CW - WW)'(0), active_width_next[j], 1'b0});
      end
    end
    result_next.pin_0        = pins[0];
    result_next.pin_1        = pins[1];
    result_next.pin_2        = pins[2];
    result_next.pin_3        = pins[3];
    result_next.pin_4        = pins[4];
    result_next.pin_5        = pins[5];
    result_next.period_start = wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tick_count   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        active_width[i]  <= '0;
        pending_width[i] <= '0;
      end
    end else begin
      if (en_out) result_valid <= v3;
      if (do_step) begin
        tick_count <= tick_count_next;
        for (int i = 0; i < CHANNELS; i++) begin
          active_width[i] <= active_width_next[i];
          if (k3 == sapg_pkg::KIND_LOAD) pending_width[i] <= width_c[i];
        end
      end
    end
    if (do_step) result <= result_next;
  end

  // checks
  a_load_holds_count: assert property (@(posedge clk) disable iff (rst)
    (do_step && k3 == sapg_pkg::KIND_LOAD) |=> (tick_count == $past(tick_count)))
    else $error("load beat moved the period counter");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    (do_step && wrap) |=> (tick_count == '0 && result.period_start && result_valid))
    else $error("wrap did not restart the period");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (v1 && v2 && v3 && result_valid && result_stall))
    else $error("input stalled with room in the pipe");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (do_step && k3 == sapg_pkg::KIND_TICK && !wrap)
      |=> (tick_count == $past(tick_count) + 1'b1))
    else $error("tick beat did not advance the counter");

endmodule

// File: test/sapg_pwm_monitor.sv
`timescale 1ns / 1ps

module sapg_pwm_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  sapg_pkg::item_t              item,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  sapg_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sapg_pkg::ADDR_W-1:0]  paddr,
  input  logic [sapg_pkg::DATA_W-1:0]  pwdata,
  output int                           fails,
  output int                           awaited
);

  localparam int DEG_SPAN = 180;
  localparam int NFIELDS  = sapg_pkg::PIN_FIELDS + 1;
  localparam int NCH      = sapg_pkg::CHANNELS_DEF;
  localparam int CNT_W    = sapg_pkg::COUNT_W;
  localparam int WID_W    = sapg_pkg::WIDTH_W;

  logic [CNT_W-1:0] period_len;
  logic [WID_W-1:0] arm_base, arm_range, grip_base, grip_range, arm_limit;
  logic [CNT_W-1:0] tick_pos;
  logic [WID_W-1:0] live_w   [NCH];
  logic [WID_W-1:0] queued_w [NCH];

  sapg_pkg::result_t pin_levels_q [$];
  sapg_pkg::result_t want;
  string   field_name [NFIELDS] = '{"pin_0", "pin_1", "pin_2", "pin_3", "pin_4", "pin_5",
                                    "period_start"};

  function automatic int scaled_width(int angle, int base, int span);
    return base + (angle * span) / DEG_SPAN;
  endfunction

  // advances the servo state by one beat and returns the pin levels after it
  function automatic sapg_pkg::result_t servo_levels(sapg_pkg::item_t it);
    int                angle [NCH];
    int                w;
    logic [CNT_W:0]    nxt;
    sapg_pkg::result_t r;
    angle = '{int'(it.angle_0), int'(it.angle_1), int'(it.angle_2), int'(it.angle_3),
              int'(it.angle_4), int'(it.angle_5)};
    r = '0;
    if (it.kind == sapg_pkg::KIND_LOAD) begin
      for (int i = 0; i < NCH; i++) begin
        if (i == NCH - 1) begin
          w = scaled_width(angle[i], int'(grip_base), int'(grip_range));
          if (w > int'(sapg_pkg::WIDTH_MAX)) w = int'(sapg_pkg::WIDTH_MAX);
        end else begin
          w = scaled_width(angle[i], int'(arm_base), int'(arm_range));
          if (w > int'(arm_limit)) w = int'(arm_limit);
        end
        queued_w[i] = w[WID_W-1:0];
      end
    end else begin
      nxt = tick_pos + 1'b1;
      if (nxt >= period_len) begin
        nxt = '0;
        r.period_start = 1'b1;
        for (int i = 0; i < NCH; i++) live_w[i] = queued_w[i];
      end
      tick_pos = nxt[CNT_W-1:0];
    end
    for (int i = 0; i < NCH; i++)
      r[NFIELDS-1-i] = (32'(tick_pos) < 2 * 32'(live_w[i]));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      period_len = sapg_pkg::PERIOD_RST;
      arm_base   = sapg_pkg::ARM_MIN_RST;
      arm_range  = sapg_pkg::ARM_SPAN_RST;
      grip_base  = sapg_pkg::GRIP_MIN_RST;
      grip_range = sapg_pkg::GRIP_SPAN_RST;
      arm_limit  = sapg_pkg::CLAMP_RST;
      tick_pos   = '0;
      for (int i = 0; i < NCH; i++) begin
        live_w[i]   = '0;
        queued_w[i] = '0;
      end
      pin_levels_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[sapg_pkg::ADDR_W-1:2])
          sapg_pkg::REG_PERIOD:    period_len = pwdata[CNT_W-1:0];
          sapg_pkg::REG_ARM_MIN:   arm_base   = pwdata[WID_W-1:0];
          sapg_pkg::REG_ARM_SPAN:  arm_range  = pwdata[WID_W-1:0];
          sapg_pkg::REG_GRIP_MIN:  grip_base  = pwdata[WID_W-1:0];
          sapg_pkg::REG_GRIP_SPAN: grip_range = pwdata[WID_W-1:0];
          sapg_pkg::REG_CLAMP:     arm_limit  = pwdata[WID_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        pin_levels_q.push_back(servo_levels(item));
      if (result_valid && !result_stall) begin
        if (pin_levels_q.size() == 0) begin
          $error("result beat %b arrived with nothing expected", result);
          fails++;
        end else begin
          want = pin_levels_q.pop_front();
          for (int k = 0; k < NFIELDS; k++) begin
            if (want[NFIELDS-1-k] !== result[NFIELDS-1-k]) begin
              $error("%s: expected %0b, got %0b", field_name[k], want[NFIELDS-1-k],
                     result[NFIELDS-1-k]);
              fails++;
            end
          end
        end
      end
    end
    awaited = pin_levels_q.size();
  end

endmodule

// File: test/servo_angle_pwm_generator_tb.sv
`timescale 1ns / 1ps

module servo_angle_pwm_generator_tb;

  localparam int unsigned LIMIT = 400000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BEATS    = 166;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int AGW            = sapg_pkg::ANGLE_W;
  localparam int DW             = sapg_pkg::DATA_W;
  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        item_valid;
  logic                        item_stall;
  sapg_pkg::item_t             item;
  logic                        result_valid;
  logic                        result_stall;
  sapg_pkg::result_t           result;
  logic                        psel, penable, pwrite, pready;
  logic [sapg_pkg::ADDR_W-1:0] paddr;
  logic [DW-1:0]               pwdata, prdata;

  int          fails, awaited;
  int unsigned cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          long_hold = 1'b0;

  always #2 clk = ~clk;

  servo_angle_pwm_generator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sapg_pwm_monitor mon (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .awaited(awaited)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic sapg_pkg::item_t load_beat(int a0, int a1, int a2, int a3, int a4,
                                                int a5);
    sapg_pkg::item_t b;
    b.kind    = sapg_pkg::KIND_LOAD;
    b.angle_0 = a0[AGW-1:0];
    b.angle_1 = a1[AGW-1:0];
    b.angle_2 = a2[AGW-1:0];
    b.angle_3 = a3[AGW-1:0];
    b.angle_4 = a4[AGW-1:0];
    b.angle_5 = a5[AGW-1:0];
    return b;
  endfunction

  function automatic sapg_pkg::item_t tick_beat();
    sapg_pkg::item_t b;
    logic [63:0]     raw;
    raw = {$urandom, $urandom};
    b = raw[$bits(sapg_pkg::item_t)-1:0];
    b.kind = sapg_pkg::KIND_TICK;
    return b;
  endfunction

  function automatic int rand_angle();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 180);
  endfunction

  function automatic sapg_pkg::item_t rand_beat();
    if ($urandom_range(0, 99) < 25)
      return load_beat(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                       rand_angle());
    return tick_beat();
  endfunction

  task automatic send_item(input sapg_pkg::item_t b);
    if ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    item       <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(tick_beat());
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int period, input int amin, input int aspan,
                           input int gmin, input int gspan, input int clamp);
    write_reg(sapg_pkg::REG_PERIOD, DW'(period));
    write_reg(sapg_pkg::REG_ARM_MIN, DW'(amin));
    write_reg(sapg_pkg::REG_ARM_SPAN, DW'(aspan));
    write_reg(sapg_pkg::REG_GRIP_MIN, DW'(gmin));
    write_reg(sapg_pkg::REG_GRIP_SPAN, DW'(gspan));
    write_reg(sapg_pkg::REG_CLAMP, DW'(clamp));
  endtask

  // sender pauses until every outstanding beat has come back
  task automatic settle();
    item_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic pick_setting(input int p);
    if (p == 1) begin
      configure(65535, 4095, 4095, 4095, 4095, 4095);
    end else if (p == 3) begin
      configure(2, 0, 0, 0, 0, 0);
    end else begin
      case ($urandom_range(0, 2))
        0: configure($urandom_range(2, 400), $urandom_range(0, 60), $urandom_range(0, 400),
                     $urandom_range(0, 60), $urandom_range(0, 400), $urandom_range(0, 200));
        1: configure($urandom_range(2, 20), $urandom_range(0, 8), $urandom_range(0, 20),
                     $urandom_range(0, 8), $urandom_range(0, 20), $urandom_range(0, 12));
        default: configure($urandom_range(2, 65535), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults, widths still zero
    send_item(load_beat(0, 0, 0, 0, 0, 0));
    send_ticks(1);
    send_item(load_beat(255, 255, 255, 255, 255, 255));
    send_item(load_beat(180, 180, 180, 180, 180, 180));
    send_item(load_beat(1, 90, 179, 181, 200, 128));
    send_ticks(2);

    // widest settings: arm clamp at the top, gripper saturates
    settle();
    configure(4, 0, 4095, 4095, 4095, 4095);
    write_reg(REG_UNMAPPED, '1);
    send_item(load_beat(255, 255, 255, 255, 255, 255));
    send_ticks(4);
    send_item(load_beat(0, 0, 0, 0, 0, 0));
    send_ticks(4);

    // period of one wraps on every tick; arm clamp bites
    settle();
    configure(1, 3, 180, 0, 0, 5);
    send_item(load_beat(0, 1, 2, 180, 255, 255));
    send_ticks(2);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      pick_setting(p);
      gap_pct   = (p == 5 || p == RAND_PHASES - 1) ? 0 : $urandom_range(5, 30);
      stall_pct = (p == 5 || p == RAND_PHASES - 1) ? 0 : $urandom_range(5, 25);
      if (p == 2) long_hold = 1'b1;
      repeat (PHASE_BEATS) send_item(rand_beat());
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sapg_pkg.sv
rtl/servo_angle_pwm_generator.sv
test/sapg_pwm_monitor.sv
test/servo_angle_pwm_generator_tb.sv
